// File: rtl/rvs_pkg.sv
// Package with the item types, opcodes, status codes and sequencer states of the RV32I step core.
package rvs_pkg;

	typedef struct packed {
		logic        func;
		logic [11:0] load_address;
		logic [31:0] load_word;
		logic        irq_pending;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pc_after;
		logic [31:0] executed_word;
		logic        reg_written;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic        mem_written;
		logic [31:0] mem_address;
		logic [1:0]  status;
		logic        irq_taken;
		logic        irq_returned;
	} out_item_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] data;
	} rf_wr_t;

	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;

	localparam logic [31:0] MRET_WORD = 32'h3020_0073;
	localparam logic [6:0]  F7_ALT    = 7'h20;
	localparam logic [6:0]  F7_BASE   = 7'h00;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_MISALIGNED = 2'd1;
	localparam logic [1:0] ST_UNKNOWN    = 2'd2;
	localparam logic [1:0] ST_MRET_IDLE  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH0,
		S_FETCH1,
		S_FETCH2,
		S_EXEC,
		S_MEM,
		S_DONE
	} seq_state_t;

endpackage

// File: rtl/rvs_regfile.sv
// Register file: a 32 x 32 memory with two registered read ports and one write port.
module rvs_regfile
	import rvs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4:0]  raddr1,
	input  logic [4:0]  raddr2,
	output logic [31:0] rdata1,
	output logic [31:0] rdata2,
	input  rf_wr_t      wr
);

	logic [31:0] mem [32];
	logic [31:0] valid_q;

	// An entry never written reads as zero; x0 is never written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en && wr.idx != 5'd0) begin
			valid_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx != 5'd0) begin
			mem[wr.idx] <= wr.data;
		end
		rdata1 <= valid_q[raddr1] ? mem[raddr1] : 32'd0;
		rdata2 <= valid_q[raddr2] ? mem[raddr2] : 32'd0;
	end

endmodule

// File: rtl/rv32i_instruction_step.sv
// Top level of the RV32I step core: sequencer, unified memory, execute logic and result register.
// A load item writes one word. A step item reads the register file and the unified memory, which
// has one read port, in turn: two fetch reads, one register read, execute, one data read for a
// load or store (a store writes the merged word back in the memory state), and a commit step that
// waits while the output register is full and not taken. The finished
// result waits in an output register while the next item is already taken. MEM_WORDS must be
// a power of two; byte addresses wrap at MEM_WORDS*4.
module rv32i_instruction_step
	import rvs_pkg::*;
#(
	parameter int MEM_WORDS = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int AW = $clog2(MEM_WORDS);

	seq_state_t state_q, state_d;

	logic [31:0] mem [MEM_WORDS];
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;

	logic [31:0] irq_vector_q, pc_q, return_pc_q;
	logic        in_handler_q;
	in_item_t    item_q;
	logic [31:0] w0_q, inst_q;
	logic [31:0] res_q, next_q, addr_q;
	logic        wr_q, mw_q, ret_q;
	logic [1:0]  status_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic [31:0] rs1_val, rs2_val;
	rf_wr_t      rf_wr;
	logic [31:0] inst_fetch;
	logic [4:0]  rf_ra1, rf_ra2;

	logic [31:0] ex_res, ex_next, ex_addr;
	logic        ex_wr, ex_mem, ex_ret;
	logic [1:0]  ex_status;

	logic [31:0] ld_res, st_word;
	logic        commit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Unified memory with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata <= mem[mem_raddr];
	end

	rvs_regfile u_rf (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr1 (rf_ra1),
		.raddr2 (rf_ra2),
		.rdata1 (rs1_val),
		.rdata2 (rs2_val),
		.wr     (rf_wr)
	);

	// The instruction may straddle two words when pc is not word aligned.
	always_comb begin
		logic [63:0] pair;
		pair       = {mem_rdata, w0_q} >> {pc_q[1:0], 3'b000};
		inst_fetch = pair[31:0];
	end
	// After the fetch the register operands keep coming from the latched instruction.
	assign rf_ra1 = (state_q == S_FETCH2) ? inst_fetch[19:15] : inst_q[19:15];
	assign rf_ra2 = (state_q == S_FETCH2) ? inst_fetch[24:20] : inst_q[24:20];

	// Execute.
	always_comb begin
		logic [6:0]  opc, f7;
		logic [2:0]  f3;
		logic [31:0] imm_i, imm_s, imm_b, imm_j, a, b;
		logic        t;
		opc   = inst_q[6:0];
		f3    = inst_q[14:12];
		f7    = inst_q[31:25];
		a     = rs1_val;
		b     = rs2_val;
		imm_i = {{20{inst_q[31]}}, inst_q[31:20]};
		imm_s = {{20{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
		imm_b = {{19{inst_q[31]}}, inst_q[31], inst_q[7], inst_q[30:25], inst_q[11:8], 1'b0};
		imm_j = {{11{inst_q[31]}}, inst_q[31], inst_q[19:12], inst_q[20], inst_q[30:21], 1'b0};
		t         = 1'b0;
		ex_res    = '0;
		ex_wr     = 1'b0;
		ex_mem    = 1'b0;
		ex_ret    = 1'b0;
		ex_addr   = '0;
		ex_status = ST_OK;
		ex_next   = pc_q + 32'd4;
		case (opc)
			OP_LUI: begin
				ex_res = {inst_q[31:12], 12'd0};
				ex_wr  = 1'b1;
			end
			OP_AUIPC: begin
				ex_res = pc_q + {inst_q[31:12], 12'd0};
				ex_wr  = 1'b1;
			end
			OP_JAL: begin
				ex_res  = pc_q + 32'd4;
				ex_wr   = 1'b1;
				ex_next = pc_q + imm_j;
			end
			OP_JALR: begin
				ex_res  = pc_q + 32'd4;
				ex_wr   = 1'b1;
				ex_next = (a + imm_i) & ~32'd1;
			end
			OP_BRANCH: begin
				case (f3)
					3'd0: t = (a == b);
					3'd1: t = (a != b);
					3'd4: t = ($signed(a) < $signed(b));
					3'd5: t = !($signed(a) < $signed(b));
					3'd6: t = (a < b);
					3'd7: t = (a >= b);
					default: ex_status = ST_UNKNOWN;
				endcase
				if (t) begin
					ex_next = pc_q + imm_b;
				end
			end
			OP_IMM: begin
				ex_wr = 1'b1;
				case (f3)
					3'd0: ex_res = a + imm_i;
					3'd1: ex_res = a << inst_q[24:20];
					3'd2: ex_res = {31'd0, $signed(a) < $signed(imm_i)};
					3'd3: ex_res = {31'd0, a < imm_i};
					3'd4: ex_res = a ^ imm_i;
					3'd6: ex_res = a | imm_i;
					3'd7: ex_res = a & imm_i;
					default: ex_res = (f7 == F7_ALT) ? 32'($signed(a) >>> inst_q[24:20])
					                                 : a >> inst_q[24:20];
				endcase
			end
			OP_REG: begin
				ex_wr = 1'b1;
				case (f3)
					3'd0: begin
						if (f7 == F7_BASE) begin
							ex_res = a + b;
						end else if (f7 == F7_ALT) begin
							ex_res = a - b;
						end else begin
							ex_wr     = 1'b0;
							ex_status = ST_UNKNOWN;
						end
					end
					3'd1: ex_res = a << b[4:0];
					3'd2: ex_res = {31'd0, $signed(a) < $signed(b)};
					3'd3: ex_res = {31'd0, a < b};
					3'd4: ex_res = a ^ b;
					3'd5: ex_res = (f7 == F7_ALT) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
					3'd6: ex_res = a | b;
					default: ex_res = a & b;
				endcase
			end
			OP_LOAD: begin
				ex_addr = a + imm_i;
				case (f3)
					3'd2: begin
						if (ex_addr[1:0] != 2'd0) ex_status = ST_MISALIGNED;
						else ex_mem = 1'b1;
					end
					3'd0, 3'd4: ex_mem = 1'b1;
					3'd1, 3'd5: begin
						if (ex_addr[0]) ex_status = ST_MISALIGNED;
						else ex_mem = 1'b1;
					end
					default: ex_status = ST_UNKNOWN;
				endcase
			end
			OP_STORE: begin
				ex_addr = a + imm_s;
				case (f3)
					3'd2: begin
						if (ex_addr[1:0] != 2'd0) ex_status = ST_MISALIGNED;
						else ex_mem = 1'b1;
					end
					3'd0: ex_mem = 1'b1;
					3'd1: begin
						if (ex_addr[0]) ex_status = ST_MISALIGNED;
						else ex_mem = 1'b1;
					end
					default: ex_status = ST_UNKNOWN;
				endcase
			end
			default: begin
				if (inst_q == MRET_WORD) begin
					if (in_handler_q) begin
						ex_next = return_pc_q;
						ex_ret  = 1'b1;
					end else begin
						ex_status = ST_MRET_IDLE;
					end
				end else begin
					ex_status = ST_UNKNOWN;
				end
			end
		endcase
	end

	// Data phase: the accessed bytes always lie within one word.
	always_comb begin
		logic [31:0] sh_word, bmask;
		logic [4:0]  sh;
		sh      = {addr_q[1:0], 3'b000};
		sh_word = mem_rdata >> sh;
		case (inst_q[14:12])
			3'd0:    ld_res = {{24{sh_word[7]}}, sh_word[7:0]};
			3'd4:    ld_res = {24'd0, sh_word[7:0]};
			3'd1:    ld_res = {{16{sh_word[15]}}, sh_word[15:0]};
			3'd5:    ld_res = {16'd0, sh_word[15:0]};
			default: ld_res = mem_rdata;
		endcase
		case (inst_q[14:12])
			3'd0:    bmask = 32'h0000_00FF << sh;
			3'd1:    bmask = 32'h0000_FFFF << sh;
			default: bmask = 32'hFFFF_FFFF;
		endcase
		st_word = (mem_rdata & ~bmask) | ((rs2_val << sh) & bmask);
	end

	// Sequencer.
	always_comb begin
		state_d   = state_q;
		mem_raddr = pc_q[AW+1:2];
		mem_we    = 1'b0;
		mem_waddr = AW'(item_q.load_address);
		mem_wdata = st_word;
		commit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				mem_waddr = AW'(in_item.load_address);
				mem_wdata = in_item.load_word;
				if (in_valid) begin
					mem_we  = !in_item.func;
					state_d = in_item.func ? S_FETCH0 : S_DONE;
				end
			end
			S_FETCH0: state_d = S_FETCH1;
			S_FETCH1: begin
				mem_raddr = pc_q[AW+1:2] + AW'(1);
				state_d   = S_FETCH2;
			end
			S_FETCH2: state_d = S_EXEC;
			S_EXEC: begin
				mem_raddr = ex_addr[AW+1:2];
				state_d   = ex_mem ? S_MEM : S_DONE;
			end
			S_MEM: begin
				mem_waddr = addr_q[AW+1:2];
				mem_we    = (inst_q[6:0] == OP_STORE);
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rf_wr.en   = commit && item_q.func && wr_q;
		rf_wr.idx  = inst_q[11:7];
		rf_wr.data = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			irq_vector_q <= '0;
			pc_q         <= '0;
			return_pc_q  <= '0;
			in_handler_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				irq_vector_q <= cfg_wdata;
			end
			out_valid_q <= commit || (out_valid_q && !out_ready);
			if (commit) begin
				if (item_q.func) begin
					if (!(in_handler_q && !ret_q) && item_q.irq_pending) begin
						return_pc_q  <= next_q;
						pc_q         <= irq_vector_q;
						in_handler_q <= 1'b1;
					end else begin
						pc_q         <= next_q;
						in_handler_q <= in_handler_q && !ret_q;
					end
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (state_q == S_FETCH1) begin
			w0_q <= mem_rdata;
		end
		if (state_q == S_FETCH2) begin
			inst_q <= inst_fetch;
		end
		if (state_q == S_EXEC) begin
			res_q    <= ex_res;
			wr_q     <= ex_wr || (ex_mem && inst_q[6:0] == OP_LOAD);
			next_q   <= ex_next;
			addr_q   <= ex_addr;
			status_q <= ex_status;
			ret_q    <= ex_ret;
			mw_q     <= ex_mem && (inst_q[6:0] == OP_STORE);
		end
		if (state_q == S_MEM && inst_q[6:0] == OP_LOAD) begin
			res_q <= ld_res;
		end
		if (commit) begin
			if (item_q.func) begin
				logic taken, wrote;
				taken = !(in_handler_q && !ret_q) && item_q.irq_pending;
				wrote = wr_q && (inst_q[11:7] != 5'd0);
				out_q.pc_after      <= taken ? irq_vector_q : next_q;
				out_q.executed_word <= inst_q;
				out_q.reg_written   <= wrote;
				out_q.dest_index    <= wrote ? inst_q[11:7] : 5'd0;
				out_q.dest_value    <= wrote ? res_q : 32'd0;
				out_q.mem_written   <= mw_q;
				out_q.mem_address   <= addr_q;
				out_q.status        <= status_q;
				out_q.irq_taken     <= taken;
				out_q.irq_returned  <= ret_q;
			end else begin
				out_item_t load_res;
				load_res          = '0;
				load_res.pc_after = pc_q;
				out_q <= load_res;
			end
		end
	end

endmodule

// File: rtl/rvs_checker.sv
// Port checker for the RV32I step core and its bind to the top level.
module rvs_checker
	import rvs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an item");

	a_dest_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.reg_written |-> out_item.dest_index == 5'd0
			&& out_item.dest_value == 32'd0)
		else $error("destination fields set without a register write");

	a_store_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.mem_written |-> out_item.status == ST_OK
			&& !out_item.reg_written)
		else $error("store reported together with a fault or register write");

endmodule

bind rv32i_instruction_step rvs_checker u_rvs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
